@@ hdl/first_fit_capacity_allocator_macros.svh @@
// Assertion macros for the first-fit capacity allocator.
// Used by the top level; depends on nothing else.
`ifndef FIRST_FIT_CAPACITY_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_CAPACITY_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define FCAP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fcap assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define FCAP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fcap assertion failed");
`else
`define FCAP_ASSERT_SAME(label, clk, rst, ante, cons)
`define FCAP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ hdl/fcap_pkg.sv @@
// Shared constants for the first-fit capacity allocator.
// No dependencies; imported by the tree RAM and the top level.
`default_nettype none

package fcap_pkg;

   // Field widths of the request and response transfers.
   localparam int CMD_W    = 1;
   localparam int BIN_W    = 10;
   localparam int AMOUNT_W = 30;
   localparam int OUT_W    = 11;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

endpackage

`default_nettype wire

@@ hdl/fcap_tree_ram.sv @@
// Single-write, single-read memory holding the max tree, with registered read data.
// Depends on fcap_pkg for the data width.
`default_nettype none

module fcap_tree_ram #(
   parameter int ADDR_W = 11
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [ADDR_W-1:0]             wr_addr,
   input  wire logic [fcap_pkg::AMOUNT_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0]             rd_addr,
   output logic      [fcap_pkg::AMOUNT_W-1:0] rd_data
);
   import fcap_pkg::*;

   localparam int DEPTH = 1 << ADDR_W;

   logic [AMOUNT_W-1:0] mem [DEPTH];
   logic [AMOUNT_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; a read of the address being written returns the old value.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/first_fit_capacity_allocator.sv @@
// First-fit capacity allocator: top level with the sequencer that walks the max tree.
// Depends on fcap_pkg, fcap_tree_ram and first_fit_capacity_allocator_macros.svh.
`default_nettype none
//
// Usage
// A command transfer happens on a rising edge where start is high and busy is low.
// req_cmd selects a load (set the capacity of bin req_bin_index to req_amount) or an
// allocation (find the lowest bin with free capacity of at least req_amount, take the
// amount from it and report the bin number counted from one, or zero if none fits).
// A load gives no response. An allocation gives one response: rsp_valid is high for
// exactly one cycle with rsp_assigned_bin; the receiver cannot stall it.
// Sequence, with L = clog2(NUM_BINS) tree levels (L = 10 by default):
//   load in range:      leaf write, then busy while the L levels are climbed (one tree level climbed per cycle);
//   load out of range:  ignored, busy stays low;
//   failed allocation:  root check, response strobe in the same cycle as busy drops;
//   granted allocation: root check, descent, leaf update and climb; response strobe
//                       while busy is still high during the climb.
// Every cycle does one read and at most one write on the single tree RAM; the descent
// and the ancestor refresh each visit one level per cycle through that port pair.
// After reset the block clears all 2*2^L tree entries (2048 by default), one per cycle,
// with busy high, so busy stays high after reset is released until the clear is done.
//
`include "first_fit_capacity_allocator_macros.svh"

module first_fit_capacity_allocator #(
   parameter int NUM_BINS = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [fcap_pkg::CMD_W-1:0]    req_cmd,
   input  wire logic [fcap_pkg::BIN_W-1:0]    req_bin_index,
   input  wire logic [fcap_pkg::AMOUNT_W-1:0] req_amount,
   output logic                               rsp_valid,
   output logic      [fcap_pkg::OUT_W-1:0]    rsp_assigned_bin
);
   import fcap_pkg::*;

   localparam int LVLS   = $clog2(NUM_BINS);
   localparam int LEAVES = 1 << LVLS;
   localparam int NW     = LVLS + 1;
   localparam logic [NW-1:0] ROOT_NODE = NW'(1);
   localparam logic [NW-1:0] ROOT_LEFT = NW'(2);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROOT,
      ST_DESCEND,
      ST_LEAF,
      ST_CLIMB
   } state_type;

   state_type           state_ff, state_in;
   logic [NW-1:0]       node_ff, node_in;
   logic [NW-1:0]       clr_ff, clr_in;
   logic [AMOUNT_W-1:0] val_ff, val_in;
   logic [AMOUNT_W-1:0] amt_ff, amt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]    rsp_bin_ff, rsp_bin_in;

   logic                wr_en;
   logic [NW-1:0]       wr_addr;
   logic [AMOUNT_W-1:0] wr_data;
   logic [NW-1:0]       rd_addr;
   logic [AMOUNT_W-1:0] rd_data;

   logic [31:0]         leaf_wide;
   logic [NW-1:0]       load_leaf;
   logic                load_ok;
   logic                go_right;
   logic [NW-1:0]       child;
   logic [NW-1:0]       parent;
   logic [AMOUNT_W-1:0] max_val;
   logic [31:0]         bin_wide;

   // Tree storage.
   fcap_tree_ram #(
      .ADDR_W (NW)
   ) u_tree_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Address arithmetic shared by the load, descent and climb steps.
   always_comb begin
      leaf_wide = 32'(LEAVES) + 32'(req_bin_index);
      load_leaf = leaf_wide[NW-1:0];
      load_ok   = 32'(req_bin_index) < 32'(NUM_BINS);
      go_right  = rd_data < amt_ff;
      child     = {node_ff[NW-2:0], go_right};
      parent    = {1'b0, node_ff[NW-1:1]};
      max_val   = (val_ff > rd_data) ? val_ff : rd_data;
      bin_wide  = 32'(node_ff[LVLS-1:0]) + 32'd1;
   end

   // Sequencer: next state, memory port control and response.
   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      clr_in       = clr_ff;
      val_in       = val_ff;
      amt_in       = amt_ff;
      rsp_valid_in = 1'b0;
      rsp_bin_in   = rsp_bin_ff;
      wr_en        = 1'b0;
      wr_addr      = node_ff;
      wr_data      = val_ff;
      rd_addr      = node_ff;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + NW'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (start) begin
               amt_in = req_amount;
               if (req_cmd == CMD_ALLOC) begin
                  rd_addr  = ROOT_NODE;
                  state_in = ST_ROOT;
               end else if (load_ok) begin
                  // Write the leaf and fetch its sibling for the first refresh.
                  wr_en    = 1'b1;
                  wr_addr  = load_leaf;
                  wr_data  = req_amount;
                  rd_addr  = {load_leaf[NW-1:1], ~load_leaf[0]};
                  node_in  = load_leaf;
                  val_in   = req_amount;
                  state_in = ST_CLIMB;
               end
            end
         end

         ST_ROOT: begin
            // The root holds the largest free capacity of all bins.
            if (rd_data < amt_ff) begin
               rsp_valid_in = 1'b1;
               rsp_bin_in   = '0;
               state_in     = ST_IDLE;
            end else begin
               node_in  = ROOT_NODE;
               rd_addr  = ROOT_LEFT;
               state_in = ST_DESCEND;
            end
         end

         ST_DESCEND: begin
            // The read data is the left child; prefer it whenever it fits.
            node_in = child;
            if (child[NW-1]) begin
               rd_addr  = child;
               state_in = ST_LEAF;
            end else begin
               rd_addr = {child[NW-2:0], 1'b0};
            end
         end

         ST_LEAF: begin
            wr_en        = 1'b1;
            wr_addr      = node_ff;
            wr_data      = rd_data - amt_ff;
            val_in       = rd_data - amt_ff;
            rd_addr      = {node_ff[NW-1:1], ~node_ff[0]};
            rsp_valid_in = 1'b1;
            rsp_bin_in   = bin_wide[OUT_W-1:0];
            state_in     = ST_CLIMB;
         end

         ST_CLIMB: begin
            // Refresh one ancestor per cycle from the carried value and its sibling.
            wr_en   = 1'b1;
            wr_addr = parent;
            wr_data = max_val;
            rd_addr = {parent[NW-1:1], ~parent[0]};
            node_in = parent;
            val_in  = max_val;
            if (parent == ROOT_NODE) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff    <= node_in;
      val_ff     <= val_in;
      amt_ff     <= amt_in;
      rsp_bin_ff <= rsp_bin_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_assigned_bin = rsp_bin_ff;

   // A response only follows the root check or the leaf update.
   `FCAP_ASSERT_NEXT(a_rsp_source, clock, reset, !(state_ff == ST_ROOT || state_ff == ST_LEAF), !rsp_valid)
   // The descent never stands on a leaf before it reads one.
   `FCAP_ASSERT_SAME(a_descend_inner, clock, reset, state_ff == ST_DESCEND, !node_ff[NW-1])
   // The climb always carries a node below the root.
   `FCAP_ASSERT_SAME(a_climb_below_root, clock, reset, state_ff == ST_CLIMB, node_ff != ROOT_NODE)

endmodule

`default_nettype wire
